/* rtl/sbp_pkg.sv */
// Shared constants, types and byte-mask helpers for the stream byte packer.
`default_nettype none
package sbp_pkg;

  localparam int DATA_W        = 64;
  localparam int KEEP_W        = 8;
  localparam int LANE_MAX      = 8;   // byte lanes the data field can carry
  localparam int BEAT_BYTES_DEF = 8;
  localparam int CNT_W         = 4;   // byte counts 0 .. 15

  typedef logic [CNT_W-1:0] cnt_t;

  // Classified input word as it waits between front and back.
  typedef struct packed {
    logic [DATA_W-1:0] data;   // valid bytes only, upper bytes zero
    cnt_t              cnt;    // number of valid bytes
    logic              last;
  } entry_t;

  // One result word.
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [KEEP_W-1:0] keep;
    logic              last;
    logic              run_end;
  } res_t;

  // Mask covering the low n bytes of a data word.
  function automatic logic [DATA_W-1:0] byte_mask(input cnt_t n);
    logic [DATA_W-1:0] m;
    if (n >= cnt_t'(LANE_MAX)) begin
      m = '1;
    end else begin
      m = (DATA_W'(1) << {n, 3'b000}) - DATA_W'(1);
    end
    return m;
  endfunction

  // Keep mask with the low n lanes set.
  function automatic logic [KEEP_W-1:0] lane_mask(input cnt_t n);
    logic [KEEP_W-1:0] m;
    if (n >= cnt_t'(KEEP_W)) begin
      m = '1;
    end else begin
      m = KEEP_W'((9'(1) << n) - 9'(1));
    end
    return m;
  endfunction

endpackage
`default_nettype wire

/* rtl/sbp_in_if.sv */
// Input channel of the stream byte packer: valid, ready and one input word.
`default_nettype none
interface sbp_in_if import sbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] in_data;
  logic [KEEP_W-1:0] in_keep;
  logic              in_last;

  modport source (output valid, in_data, in_keep, in_last, input ready);
  modport sink   (input valid, in_data, in_keep, in_last, output ready);
endinterface
`default_nettype wire

/* rtl/sbp_out_if.sv */
// Output channel of the stream byte packer: valid, ready and one result word.
`default_nettype none
interface sbp_out_if import sbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] out_data;
  logic [KEEP_W-1:0] out_keep;
  logic              out_last;
  logic              run_end;

  modport source (output valid, out_data, out_keep, out_last, run_end, input ready);
  modport sink   (input valid, out_data, out_keep, out_last, run_end, output ready);
endinterface
`default_nettype wire

/* rtl/stream_byte_packer.sv */
// Top level of the stream byte packer: front, queue and back wired together.
//
//   channel   role     signals                                       handshake
//   -------   ------   -------------------------------------------   -----------
//   ingress   sink     in_data[63:0] in_keep[7:0] in_last              valid/ready
//   egress    source   out_data[63:0] out_keep[7:0] out_last run_end   valid/ready
//
// Sustained rate is one word per clock in each direction while egress holds
// ready. A last word whose bytes overflow a beat yields two result words and
// holds the back part while the second one is pending; the two-entry queue
// absorbs that. An accepted word is written into the queue at the accepting
// edge and later, from the queue head, into the back part's result register.
// Synchronous rst empties the queue, drops the held byte count and clears
// output valid; there is no clearing pass. ingress.ready drops only when the
// queue is full, so a stalled egress backs up through the queue on its own.
`default_nettype none
module stream_byte_packer import sbp_pkg::*; #(
  parameter int BEAT_BYTES = BEAT_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  sbp_in_if.sink    ingress,
  sbp_out_if.source egress
);

  // The data field carries at most eight lanes; wider beats behave as eight.
  localparam int LANES = (BEAT_BYTES > LANE_MAX) ? LANE_MAX : BEAT_BYTES;

  logic   push;
  entry_t push_entry;
  logic   q_full;
  logic   q_pop;
  logic   q_valid;
  entry_t q_head;

  // Classify incoming words: keep mask to byte count, drop bytes outside keep.
  sbp_front #(.LANES(LANES)) u_front (
    .ingress    (ingress),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Decouple: front keeps accepting while back waits on egress.
  sbp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  // Pack held and new bytes, emit full beats and last-word flushes.
  sbp_back #(.LANES(LANES)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .egress  (egress)
  );

endmodule
`default_nettype wire

/* rtl/sbp_front.sv */
// Front part: accept input words, turn the keep mask into a byte count, mask the data.
`default_nettype none
module sbp_front import sbp_pkg::*; #(
  parameter int LANES = BEAT_BYTES_DEF
) (
  sbp_in_if.sink   ingress,
  input  logic     q_full,
  output logic     push,
  output entry_t   push_entry
);

  logic [KEEP_W-1:0] keep;
  logic              keep_ok;
  cnt_t              n;

  assign keep = ingress.in_keep;

  // A mask is usable only when contiguous from lane 0 and inside the lane count.
  assign keep_ok = ((keep & ~lane_mask(cnt_t'(LANES))) == '0) &&
                   ((keep & (keep + KEEP_W'(1))) == '0);
  assign n = keep_ok ? cnt_t'($countones(keep)) : '0;

  assign ingress.ready   = !q_full;
  assign push            = ingress.valid && !q_full;
  assign push_entry.data = ingress.in_data & byte_mask(n);
  assign push_entry.cnt  = n;
  assign push_entry.last = ingress.in_last;

endmodule
`default_nettype wire

/* rtl/sbp_queue.sv */
// Two-entry queue that decouples the front and back parts.
`default_nettype none
module sbp_queue import sbp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output entry_t head
);

  entry_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_entry;
  end

endmodule
`default_nettype wire

/* rtl/sbp_back.sv */
// Back part: join held bytes with new bytes, emit full and flushed words.
`default_nettype none
module sbp_back import sbp_pkg::*; #(
  parameter int LANES = BEAT_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  entry_t     q_head,
  output logic       q_pop,
  sbp_out_if.source  egress
);

  localparam int HW = (LANES > 1) ? $clog2(LANES) : 1;

  logic [DATA_W-1:0] held_bytes;
  logic [HW-1:0]     held_count;
  logic              o_valid;
  res_t              o_res;
  logic              pend_valid;
  res_t              pend_res;

  logic [DATA_W-1:0] comb;
  logic [DATA_W-1:0] left;
  cnt_t              h;
  cnt_t              total;
  cnt_t              r;
  cnt_t              sh;
  logic              fills;
  logic              produces;
  logic              two;
  logic              slot_free;
  logic              go;
  res_t              first;
  res_t              second;

  assign h     = cnt_t'(held_count);
  assign total = h + q_head.cnt;
  assign fills = (total >= cnt_t'(LANES));
  assign r     = total - cnt_t'(LANES);
  assign sh    = cnt_t'(LANES) - h;
  assign comb  = (held_bytes & byte_mask(h)) | (q_head.data << {h, 3'b000});
  assign left  = q_head.data >> {sh, 3'b000};
  assign two   = fills && q_head.last && (r != '0);
  assign produces = fills || q_head.last;

  always_comb begin
    if (fills) begin
      first.data    = comb & byte_mask(cnt_t'(LANES));
      first.keep    = lane_mask(cnt_t'(LANES));
      first.last    = q_head.last && (r == '0);
      first.run_end = !two;
    end else begin
      first.data    = comb & byte_mask(total);
      first.keep    = lane_mask(total);
      first.last    = 1'b1;
      first.run_end = 1'b1;
    end
    second.data    = left & byte_mask(r);
    second.keep    = lane_mask(r);
    second.last    = 1'b1;
    second.run_end = 1'b1;
  end

  // Advance the head when its first result has a free slot or when it produces no
  // result; hold while a flushed remainder is still pending.
  assign slot_free = !o_valid || egress.ready;
  assign go        = q_valid && !pend_valid && (slot_free || !produces);
  assign q_pop     = go;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid    <= 1'b0;
      pend_valid <= 1'b0;
      held_count <= '0;
    end else begin
      if (slot_free) begin
        if (pend_valid) begin
          o_valid    <= 1'b1;
          pend_valid <= 1'b0;
        end else begin
          o_valid <= go && produces;
        end
      end
      if (go) begin
        if (two) pend_valid <= 1'b1;
        if (q_head.last) begin
          held_count <= '0;
        end else if (fills) begin
          held_count <= HW'(r);
        end else begin
          held_count <= HW'(total);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (pend_valid) o_res <= pend_res;
      else if (go)    o_res <= first;
    end
    if (go) begin
      if (two) pend_res <= second;
      if (q_head.last) begin
        held_bytes <= '0;
      end else if (fills) begin
        held_bytes <= left & byte_mask(r);
      end else begin
        held_bytes <= comb & byte_mask(total);
      end
    end
  end

  assign egress.valid    = o_valid;
  assign egress.out_data = o_res.data;
  assign egress.out_keep = o_res.keep;
  assign egress.out_last = o_res.last;
  assign egress.run_end  = o_res.run_end;

endmodule
`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the stream byte packer: directed and random word streams.
module tb_top;
  import sbp_pkg::*;

  localparam int BEAT_BYTES   = 8;
  // Lanes the packer really uses: the data field caps the beat at LANE_MAX bytes.
  localparam int LANES        = (BEAT_BYTES > LANE_MAX) ? LANE_MAX : BEAT_BYTES;
  localparam int IDLE_MAX     = 18;
  // A correct run never goes more than a sender gap, a receiver stall and the
  // packer's own latency without moving a word; allow many times that.
  localparam int STALL_LIMIT  = 400;
  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_PRINTS   = 40;

  logic clk = 1'b0;
  logic rst;

  sbp_in_if  in_ch ();
  sbp_out_if out_ch ();

  stream_byte_packer #(.BEAT_BYTES(BEAT_BYTES)) u_top (
    .clk     (clk),
    .rst     (rst),
    .ingress (in_ch),
    .egress  (out_ch)
  );

  always #6 clk = ~clk;

  // Packer state as the predictor sees it: bytes waiting for the next beat.
  logic [DATA_W-1:0] held_data = '0;
  int                held_cnt  = 0;
  // Result words still owed by the packer, oldest first.
  res_t              beats_due[$];

  // Longest idle stretch each side may draw per word; 0 runs at full rate.
  int in_gap_max  = 0;
  int out_gap_max = 0;

  int errors        = 0;
  int words_in      = 0;
  int words_out     = 0;
  int packets       = 0;
  int split_flushes = 0;
  int bad_keeps     = 0;
  int idle_cycles   = 0;

  // ---------------------------------------------------------------------
  // Byte and lane masks
  // ---------------------------------------------------------------------
  function automatic logic [DATA_W-1:0] low_bytes(input int n);
    if (n >= LANE_MAX) return '1;
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  function automatic logic [KEEP_W-1:0] low_lanes(input int n);
    return KEEP_W'((9'd1 << n) - 9'd1);
  endfunction

  // Byte count of a keep mask; a mask with a hole or with lanes above the
  // beat width counts as no bytes at all.
  function automatic int keep_bytes(input logic [KEEP_W-1:0] k);
    int n = 0;
    if ((k & ~low_lanes(LANES)) != '0) return 0;
    if ((k & (k + 1'b1)) != '0) return 0;
    while (k != '0) begin
      n++;
      k = k >> 1;
    end
    return n;
  endfunction

  function automatic res_t make_beat(input logic [DATA_W-1:0] d, input int cnt,
                                     input logic l);
    res_t b;
    b.data    = d & low_bytes(cnt);
    b.keep    = low_lanes(cnt);
    b.last    = l;
    b.run_end = 1'b0;
    return b;
  endfunction

  function automatic logic [DATA_W-1:0] rand_data();
    return {$urandom, $urandom};
  endfunction

  // ---------------------------------------------------------------------
  // Predictor: append the new bytes above the held ones, emit a full beat
  // when the total reaches the beat width, flush the rest on a last word.
  // ---------------------------------------------------------------------
  function automatic void pack_word(input logic [DATA_W-1:0] d,
                                    input logic [KEEP_W-1:0] k, input logic l);
    int                n;
    int                h;
    int                total;
    int                r;
    logic [DATA_W-1:0] nd;
    logic [DATA_W-1:0] comb;
    logic [DATA_W-1:0] left;
    res_t              beats[$];
    n = keep_bytes(k);
    if (n == 0 && k != '0) bad_keeps++;
    h     = held_cnt;
    nd    = d & low_bytes(n);
    comb  = (held_data & low_bytes(h)) | (nd << (8 * h));
    total = h + n;
    left  = '0;
    if (total >= LANES) begin
      r = total - LANES;
      // Upper bytes of the new word that did not fit stay for later.
      if (r > 0) left = nd >> (8 * (LANES - h));
      beats.push_back(make_beat(comb, LANES, l && (r == 0)));
      if (l) begin
        if (r > 0) beats.push_back(make_beat(left, r, 1'b1));
        held_cnt = 0;
      end else begin
        held_data = left & low_bytes(r);
        held_cnt  = r;
      end
    end else if (l) begin
      // Short or empty packet end: flush whatever is there.
      beats.push_back(make_beat(comb, total, 1'b1));
      held_cnt = 0;
    end else begin
      held_data = comb & low_bytes(total);
      held_cnt  = total;
    end
    if (beats.size() > 0) beats[beats.size() - 1].run_end = 1'b1;
    if (beats.size() == 2) split_flushes++;
    foreach (beats[i]) beats_due.push_back(beats[i]);
  endfunction

  // ---------------------------------------------------------------------
  // Ingress driver: idle for a drawn gap, then hold the word until taken.
  // ---------------------------------------------------------------------
  task automatic send_word(input logic [DATA_W-1:0] d, input logic [KEEP_W-1:0] k,
                           input logic l);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_data <= d;
    in_ch.in_keep <= k;
    in_ch.in_last <= l;
    do @(posedge clk); while (!in_ch.ready);
    // The word moved at this edge: advance the predictor.
    pack_word(d, k, l);
    words_in++;
    if (l) packets++;
  endtask

  task automatic shuffle_idle();
    case ($urandom_range(0, 3))
      0: begin
        in_gap_max  = 0;
        out_gap_max = 0;
      end
      1: begin
        in_gap_max  = 0;
        out_gap_max = IDLE_MAX;
      end
      2: begin
        in_gap_max  = IDLE_MAX;
        out_gap_max = 0;
      end
      default: begin
        in_gap_max  = $urandom_range(1, IDLE_MAX);
        out_gap_max = $urandom_range(1, IDLE_MAX);
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("%0t ns  mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------

  // Last words with no valid bytes and nothing held give one empty beat.
  task automatic test_empty_last();
    in_gap_max  = 0;
    out_gap_max = 0;
    send_word('1, 8'h00, 1'b1);
    send_word('1, 8'hA5, 1'b1);
  endtask

  // Totals of exactly one beat go out whole and leave nothing held.
  task automatic test_exact_fill();
    in_gap_max  = 2;
    out_gap_max = IDLE_MAX;
    send_word('1, 8'hFF, 1'b0);
    send_word('0, 8'hFF, 1'b1);
    send_word(rand_data(), 8'h07, 1'b0);
    send_word(rand_data(), 8'h1F, 1'b1);
    send_word(rand_data(), 8'h0F, 1'b0);
    send_word(rand_data(), 8'h0F, 1'b0);
  endtask

  // Last words that spill past a beat give a full beat plus the remainder.
  task automatic test_overflow_on_last();
    in_gap_max  = 0;
    out_gap_max = IDLE_MAX;
    send_word(rand_data(), 8'h3F, 1'b0);
    send_word(rand_data(), 8'h0F, 1'b1);
    send_word(rand_data(), 8'h7F, 1'b0);
    send_word('1, 8'hFF, 1'b1);
  endtask

  // Leftover bytes carry into the next beat and are flushed on an empty last.
  task automatic test_carry_over();
    in_gap_max  = IDLE_MAX;
    out_gap_max = 0;
    send_word(rand_data(), 8'h7F, 1'b0);
    send_word(rand_data(), 8'h03, 1'b0);
    send_word(rand_data(), 8'h01, 1'b0);
    send_word(rand_data(), 8'h00, 1'b1);
  endtask

  // Masks with holes add no bytes, yet their last flag still flushes.
  task automatic test_bad_keep();
    in_gap_max  = 1;
    out_gap_max = 1;
    send_word(rand_data(), 8'h3F, 1'b0);
    send_word(rand_data(), 8'h05, 1'b0);
    send_word('1, 8'h80, 1'b0);
    send_word(rand_data(), 8'h02, 1'b1);
  endtask

  // ---------------------------------------------------------------------
  // Random tests
  // ---------------------------------------------------------------------

  // Packets of one to six words with random fill levels; now and then a word carries an arbitrary keep mask.
  task automatic test_random_packets();
    int                sent;
    int                beats;
    bit                full_run;
    logic [KEEP_W-1:0] k;
    sent = 0;
    while (sent < 850) begin
      if ($urandom_range(0, 19) == 0) shuffle_idle();
      beats    = $urandom_range(1, 6);
      full_run = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < beats; i++) begin
        if (full_run)
          k = '1;
        else if ($urandom_range(0, 19) == 0)
          k = KEEP_W'($urandom);
        else
          k = low_lanes($urandom_range(0, LANES));
        send_word(rand_data(), k, i == beats - 1);
        sent++;
      end
    end
  endtask

  // Noise: any keep pattern, last at random.
  task automatic test_random_noise();
    logic [KEEP_W-1:0] k;
    for (int i = 0; i < 250; i++) begin
      if (i % 50 == 0) shuffle_idle();
      k = ($urandom_range(0, 1) == 0) ? KEEP_W'($urandom) : low_lanes($urandom_range(0, LANES));
      send_word(rand_data(), k, $urandom_range(0, 2) == 0);
    end
  endtask

  // ---------------------------------------------------------------------
  // Egress sink: drop ready for a drawn gap, then hold it until a word moves.
  // ---------------------------------------------------------------------
  initial begin : egress_sink
    int gap;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      gap = $urandom_range(0, out_gap_max);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Compare each result word against the oldest expected beat.
  always @(posedge clk) begin
    res_t due;
    if (!rst && out_ch.valid && out_ch.ready) begin
      words_out++;
      if (beats_due.size() == 0) begin
        report_mismatch("unexpected result word", out_ch.out_data, '0);
      end else begin
        due = beats_due.pop_front();
        if (out_ch.out_data !== due.data)
          report_mismatch("out_data", out_ch.out_data, due.data);
        if (out_ch.out_keep !== due.keep)
          report_mismatch("out_keep", DATA_W'(out_ch.out_keep), DATA_W'(due.keep));
        if (out_ch.out_last !== due.last)
          report_mismatch("out_last", DATA_W'(out_ch.out_last), DATA_W'(due.last));
        if (out_ch.run_end !== due.run_end)
          report_mismatch("run_end", DATA_W'(out_ch.run_end), DATA_W'(due.run_end));
      end
    end
  end

  // Watchdog: end the run if no word moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no word moved for %0d cycles, %0d beats still due",
               STALL_LIMIT, beats_due.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    rst           <= 1'b1;
    in_ch.valid   <= 1'b0;
    in_ch.in_data <= '0;
    in_ch.in_keep <= '0;
    in_ch.in_last <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_empty_last();
    test_exact_fill();
    test_overflow_on_last();
    test_carry_over();
    test_bad_keep();
    test_random_packets();
    test_random_noise();

    // Stop sending, wait for every owed beat, then watch for strays.
    in_ch.valid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d input words in %0d packets and checked %0d result words.",
             words_in, packets, words_out);
    $display("%0d words split into two results, %0d carried a bad keep mask, %0d mismatches.",
             split_flushes, bad_keeps, errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/sbp_pkg.sv
rtl/sbp_in_if.sv
rtl/sbp_out_if.sv
rtl/sbp_front.sv
rtl/sbp_queue.sv
rtl/sbp_back.sv
rtl/stream_byte_packer.sv
dv/tb_top.sv
